/* hw/rtl/lcdnw_pkg.sv */
// shared types and constants of the lcd nibble writer
// used by the dabble cells, the nibble emitter and the top level
package lcdnw_pkg;

  localparam int unsigned BIN_W   = 14;   // width of the value field
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DIGITS  = 4;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned NCELLS  = BIN_W;  // one shift step per cell

  localparam logic [BIN_W-1:0] MAX_DEC = BIN_W'(9999);

  localparam logic [OP_W-1:0] OP_CMD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // high nibble of an ascii digit
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // word handed from cell to cell
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BIN_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } word_t;

endpackage

/* hw/rtl/lcdnw_dabble_cell.sv */
// one cell of the binary to bcd chain: one add-3 and shift step
// depends on lcdnw_pkg
module lcdnw_dabble_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcdnw_pkg::word_t in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output lcdnw_pkg::word_t out_word
);

  lcdnw_pkg::word_t step;
  logic [lcdnw_pkg::BCD_W-1:0] adj;
  logic valid;
  lcdnw_pkg::word_t word;

  always_comb begin
    for (int d = 0; d < lcdnw_pkg::DIGITS; d++) begin
      if (in_word.bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = in_word.bcd[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = in_word.bcd[4*d +: 4];
      end
    end
    step = in_word;
    // byte items ride along untouched
    if (in_word.op == lcdnw_pkg::OP_DEC) begin
      step.bcd = {adj[lcdnw_pkg::BCD_W-2:0], in_word.bin[lcdnw_pkg::BIN_W-1]};
      step.bin = {in_word.bin[lcdnw_pkg::BIN_W-2:0], 1'b0};
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= step;
    end
  end

endmodule

/* hw/rtl/lcdnw_emitter.sv */
// nibble sequencer: splits bytes and suppressed-zero digits into nibbles
// depends on lcdnw_pkg
module lcdnw_emitter (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcdnw_pkg::word_t in_word,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic       busy;
  logic       dec;
  logic       rs;
  logic [7:0] byte_val;
  logic [lcdnw_pkg::BCD_W-1:0] digits;
  logic [1:0] pos;
  logic       half;
  logic [3:0] nib;

  logic       slot_free;
  logic       emit;
  logic       is_last;
  logic [3:0] cur_nib;
  logic [3:0] cur_digit;
  logic [1:0] start_pos;

  always_comb begin
    case (pos)
      2'd0:    cur_digit = digits[15:12];
      2'd1:    cur_digit = digits[11:8];
      2'd2:    cur_digit = digits[7:4];
      2'd3:    cur_digit = digits[3:0];
      default: cur_digit = digits[3:0];
    endcase
    if (dec) begin
      cur_nib = half ? cur_digit : lcdnw_pkg::ASCII_DIGIT_HI;
    end else begin
      cur_nib = half ? byte_val[3:0] : byte_val[7:4];
    end
    // first shown digit, units always shown
    if (in_word.bcd[15:12] != 4'd0) begin
      start_pos = 2'd0;
    end else if (in_word.bcd[11:8] != 4'd0) begin
      start_pos = 2'd1;
    end else if (in_word.bcd[7:4] != 4'd0) begin
      start_pos = 2'd2;
    end else begin
      start_pos = 2'd3;
    end
  end

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = busy && slot_free;
  assign is_last   = half && (!dec || pos == 2'd3);
  assign in_ready  = !busy || (emit && is_last);

  assign m_tdata = {4'd0, nib};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (slot_free) begin
        m_tvalid <= busy;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nib     <= cur_nib;
      m_tuser <= rs;
      m_tlast <= is_last;
    end
    if (in_valid && in_ready) begin
      dec      <= (in_word.op == lcdnw_pkg::OP_DEC);
      rs       <= (in_word.op != lcdnw_pkg::OP_CMD);
      byte_val <= in_word.bin[7:0];
      digits   <= in_word.bcd;
      pos      <= (in_word.op == lcdnw_pkg::OP_DEC) ? start_pos : 2'd3;
      half     <= 1'b0;
    end else if (emit) begin
      half <= ~half;
      if (half) begin
        pos <= pos + 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/lcd_nibble_writer_with_decimal.sv */
// top level of the 4-bit lcd writer front end with decimal display
// depends on lcdnw_pkg, lcdnw_dabble_cell and lcdnw_emitter
//
//  channel  dir  payload                              handshake
//  s_*      in   tdata: opcode[1:0] value[15:2]       s_tvalid / s_tready
//  m_*      out  tdata: nibble[3:0], tuser: reg_sel   m_tvalid / m_tready, tlast
//
// a byte item gives 2 nibbles, a number item 2 to 8 nibbles, one per cycle
// while m_tready is high: the emitter sending one nibble a cycle sets the rate.
// every item passes a chain of 14 add-3/shift cells, which change only numbers;
// the chain keeps taking items while earlier ones are still in it.
// opcode 3 is taken whenever s_tready is high and gives nothing.
// rst is synchronous and empties the chain and the output register.
// a stall on m_tready backs up cell by cell to s_tready.
module lcd_nibble_writer_with_decimal (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // opcode[1:0], value[15:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // nibble[3:0], zeros[7:4]
  output logic        m_tuser,   // reg_select
  output logic        m_tlast
);

  localparam int unsigned N = lcdnw_pkg::NCELLS;

  logic [lcdnw_pkg::OP_W-1:0]  op_in;
  logic [lcdnw_pkg::BIN_W-1:0] val_in;

  logic             c_valid [N+1];
  logic             c_ready [N+1];
  lcdnw_pkg::word_t c_word  [N+1];

  assign op_in  = s_tdata[1:0];
  assign val_in = s_tdata[15:2];

  always_comb begin
    c_word[0].op  = op_in;
    c_word[0].bcd = '0;
    // saturate numbers, bytes keep all bits (emitter uses the low eight)
    if (op_in == lcdnw_pkg::OP_DEC && val_in > lcdnw_pkg::MAX_DEC) begin
      c_word[0].bin = lcdnw_pkg::MAX_DEC;
    end else begin
      c_word[0].bin = val_in;
    end
  end

  // unused opcode is swallowed at the door
  assign c_valid[0] = s_tvalid && (op_in != lcdnw_pkg::OP_NONE);
  assign s_tready   = c_ready[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    lcdnw_dabble_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_word   (c_word[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_word  (c_word[i+1])
    );
  end

  lcdnw_emitter u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid[N]),
    .in_ready (c_ready[N]),
    .in_word  (c_word[N]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
